/* rtl/core/jmsw_pkg.sv */
// Shared types and constants for the JPEG marker segment walker.
`timescale 1ns / 1ps
`default_nettype none
package jmsw_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SOI1   = 4'd1,
    PH_MARK   = 4'd2,
    PH_FILL   = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_LEN_LO = 4'd5,
    PH_SKIP   = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_NEEDMORE  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] MARK_SOI  = 8'hD8;
  localparam logic [7:0] MARK_SOS  = 8'hDA;
  localparam logic [7:0] MARK_EOI  = 8'hD9;
  localparam logic [7:0] MARK_TEM  = 8'h01;
  localparam logic [7:0] MARK_RST0 = 8'hD0;
  localparam logic [7:0] MARK_RST7 = 8'hD7;
  localparam logic [15:0] LEN_MIN  = 16'd2;

  typedef struct packed {
    phase_e      phase;
    logic        soi_mismatch;
    logic [7:0]  length_high;
    logic [15:0] skip_remaining;
    logic        decided;
  } walk_state_t;

  typedef struct packed {
    logic    emit;
    status_e status;
  } walk_result_t;

endpackage
`default_nettype wire

/* rtl/core/jpeg_marker_segment_walker.sv */
// Top level of the JPEG marker segment walker: input register, walk state, status register.
// An accepted word waits in the input register and is walked when it advances, which also
// registers its status, if any, in the status register.
// Throughput: one word per cycle; a status that waits on the receiver holds the input.
// Reset clears the valid flags and the walk state; the walker then ignores words
// until one arrives that marks the first byte of a stream.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_marker_segment_walker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] coverage_status_o
);
  import jmsw_pkg::*;

  logic         in_valid_q;
  logic [7:0]   data_q;
  logic         first_q;
  logic         last_q;
  walk_state_t  state_q;
  walk_state_t  state_d;
  walk_result_t res;
  logic         out_valid_q;
  status_e      status_q;
  logic         advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  jmsw_step u_step (
    .cur_i        (state_q),
    .data_byte_i  (data_q),
    .first_byte_i (first_q),
    .last_byte_i  (last_q),
    .nxt_o        (state_d),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_IDLE, soi_mismatch: 1'b0, length_high: 8'd0,
                       skip_remaining: 16'd0, decided: 1'b0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
    if (advance && res.emit) begin
      status_q <= res.status;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign coverage_status_o = status_q;

endmodule
`default_nettype wire

/* rtl/core/jmsw_step.sv */
// Next-state and status logic for one stream word of the marker walk.
`timescale 1ns / 1ps
`default_nettype none
module jmsw_step (
  input  jmsw_pkg::walk_state_t  cur_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic                   last_byte_i,
  output jmsw_pkg::walk_state_t  nxt_o,
  output jmsw_pkg::walk_result_t res_o
);
  import jmsw_pkg::*;

  logic        live;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign seg_len  = {cur_i.length_high, data_byte_i};
  assign skip_dec = (cur_i.skip_remaining != 16'd0) ? cur_i.skip_remaining - 16'd1
                                                    : cur_i.skip_remaining;

  always_comb begin
    nxt_o      = cur_i;
    res_o.emit = 1'b0;
    res_o.status = ST_NEEDMORE;
    live       = 1'b0;
    if (first_byte_i) begin
      live                 = 1'b1;
      nxt_o.decided        = 1'b0;
      nxt_o.length_high    = 8'd0;
      nxt_o.skip_remaining = 16'd0;
      nxt_o.soi_mismatch   = (data_byte_i != BYTE_FILL);
      nxt_o.phase          = PH_SOI1;
    end else if (!cur_i.decided && cur_i.phase != PH_IDLE) begin
      live = 1'b1;
      unique case (cur_i.phase)
        PH_SOI1: begin
          if (cur_i.soi_mismatch || data_byte_i != MARK_SOI) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_MALFORMED;
          end else begin
            nxt_o.phase = PH_MARK;
          end
        end
        PH_MARK: begin
          if (data_byte_i != BYTE_FILL) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_MALFORMED;
          end else begin
            nxt_o.phase = PH_FILL;
          end
        end
        PH_FILL: begin
          if (data_byte_i == BYTE_FILL) begin
            nxt_o.phase = PH_FILL;
          end else if (data_byte_i == MARK_SOS || data_byte_i == MARK_EOI) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_COMPLETE;
          end else if (data_byte_i == MARK_TEM ||
                       (data_byte_i >= MARK_RST0 && data_byte_i <= MARK_RST7)) begin
            nxt_o.phase = PH_MARK;
          end else begin
            nxt_o.phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          nxt_o.length_high = data_byte_i;
          nxt_o.phase       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < LEN_MIN) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_MALFORMED;
          end else begin
            nxt_o.skip_remaining = seg_len - LEN_MIN;
            nxt_o.phase = (seg_len != LEN_MIN) ? PH_SKIP : PH_MARK;
          end
        end
        PH_SKIP: begin
          nxt_o.skip_remaining = skip_dec;
          if (skip_dec == 16'd0) begin
            nxt_o.phase = PH_MARK;
          end
        end
        default: begin
          live        = 1'b0;
          nxt_o.phase = PH_IDLE;
        end
      endcase
    end
    if (live && !res_o.emit && last_byte_i) begin
      res_o.emit   = 1'b1;
      res_o.status = ST_NEEDMORE;
    end
    if (res_o.emit) begin
      nxt_o.decided = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sim/jpeg_marker_segment_walker_test.sv */
// Self-checking testbench for the JPEG marker segment walker with a status scoreboard.
`timescale 1ns / 1ps
module jpeg_marker_segment_walker_test;
  import jmsw_pkg::*;

  class walk_scoreboard;
    phase_e      phase;
    bit          soi_bad;
    logic [7:0]  len_hi;
    logic [15:0] skip_left;
    bit          done;
    status_e     pending_q[$];
    int          errors;

    function new();
      phase     = PH_IDLE;
      soi_bad   = 1'b0;
      len_hi    = '0;
      skip_left = '0;
      done      = 1'b0;
      errors    = 0;
    endfunction

    // Walks one accepted word and returns 1 unless the word is ignored.
    function bit note_word(logic [7:0] b, bit f, bit l);
      status_e     st;
      bit          emit;
      logic [15:0] seg_len;
      emit = 1'b0;
      st = ST_NEEDMORE;
      if (f) begin
        done      = 1'b0;
        len_hi    = '0;
        skip_left = '0;
        soi_bad   = (b != BYTE_FILL);
        phase     = PH_SOI1;
      end else begin
        if (done || phase == PH_IDLE) return 1'b0;
        case (phase)
          PH_SOI1: begin
            if (soi_bad || b != MARK_SOI) begin
              emit = 1'b1;
              st = ST_MALFORMED;
            end else phase = PH_MARK;
          end
          PH_MARK: begin
            if (b != BYTE_FILL) begin
              emit = 1'b1;
              st = ST_MALFORMED;
            end else phase = PH_FILL;
          end
          PH_FILL: begin
            if (b == BYTE_FILL) begin
            end else if (b == MARK_SOS || b == MARK_EOI) begin
              emit = 1'b1;
              st = ST_COMPLETE;
            end else if (b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_RST7)) begin
              phase = PH_MARK;
            end else phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_hi = b;
            phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            seg_len = {len_hi, b};
            if (seg_len < LEN_MIN) begin
              emit = 1'b1;
              st = ST_MALFORMED;
            end else begin
              skip_left = seg_len - LEN_MIN;
              phase = (skip_left != 0) ? PH_SKIP : PH_MARK;
            end
          end
          PH_SKIP: begin
            if (skip_left > 0) skip_left = skip_left - 1'b1;
            if (skip_left == 0) phase = PH_MARK;
          end
          default: begin
            phase = PH_IDLE;
            return 1'b0;
          end
        endcase
      end
      if (!emit && l) begin
        emit = 1'b1;
        st = ST_NEEDMORE;
      end
      if (emit) begin
        done = 1'b1;
        pending_q.push_back(st);
      end
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_status(logic [1:0] got);
      status_e want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("status %0d with no word waiting", got));
      end else begin
        want = pending_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("status %0d, expected %0d", got, want));
      end
    endtask
  endclass

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 170;

  typedef struct {
    logic [7:0] data;
    bit         first;
    bit         last;
  } jpeg_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       first_byte = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] coverage_status;

  walk_scoreboard sb = new();
  jpeg_word_t     stream_q[$];
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             walked_words = 0;
  int             cycles = 0;

  jpeg_marker_segment_walker DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (data_byte),
    .first_byte_i      (first_byte),
    .last_byte_i       (last_byte),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .coverage_status_o (coverage_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("jpeg_marker_segment_walker_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_status(coverage_status);
  end

  function automatic void push_word(logic [7:0] d, bit f, bit l);
    jpeg_word_t w;
    w.data = d;
    w.first = f;
    w.last = l;
    stream_q.push_back(w);
  endfunction

  function automatic void start_stream();
    push_word(BYTE_FILL, 1'b1, 1'b0);
    push_word(MARK_SOI, 1'b0, 1'b0);
  endfunction

  function automatic void push_fills();
    int n;
    n = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
    push_word(BYTE_FILL, 1'b0, 1'b0);
    repeat (n) push_word(BYTE_FILL, 1'b0, 1'b0);
  endfunction

  function automatic void add_segment();
    logic [7:0]  mark;
    logic [15:0] seg_len;
    int          r;
    push_fills();
    if ($urandom_range(3) == 0) begin
      r = $urandom_range(8);
      push_word((r == 8) ? MARK_TEM : MARK_RST0 + 8'(r), 1'b0, 1'b0);
    end else begin
      do mark = 8'($urandom);
      while (mark == BYTE_FILL || mark == MARK_SOS || mark == MARK_EOI ||
             mark == MARK_TEM || (mark >= MARK_RST0 && mark <= MARK_RST7));
      r = $urandom_range(99);
      seg_len = (r < 8) ? 16'($urandom_range(1)) :
                (r < 88) ? 16'($urandom_range(2, 10)) : 16'($urandom_range(11, 40));
      push_word(mark, 1'b0, 1'b0);
      push_word(seg_len[15:8], 1'b0, 1'b0);
      push_word(seg_len[7:0], 1'b0, 1'b0);
      if (seg_len >= LEN_MIN) repeat (seg_len - LEN_MIN) push_word(8'($urandom), 1'b0, 1'b0);
    end
  endfunction

  function automatic void gen_stream();
    int keep;
    int idx;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 8))
        push_word(8'($urandom), stream_q.size() == 0 || $urandom_range(7) == 0,
                  $urandom_range(7) == 0);
      return;
    end
    start_stream();
    repeat ($urandom_range(4)) add_segment();
    if ($urandom_range(99) < 60) begin
      push_fills();
      push_word($urandom_range(1) ? MARK_SOS : MARK_EOI, 1'b0, 1'($urandom_range(1)));
    end else begin
      keep = $urandom_range(1, stream_q.size());
      while (stream_q.size() > keep) void'(stream_q.pop_back());
      stream_q[keep - 1].last = 1'b1;
    end
    if ($urandom_range(99) < 15) begin
      idx = $urandom_range(stream_q.size() - 1);
      stream_q[idx].data = 8'($urandom);
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) push_word(8'($urandom), 1'b0, 1'($urandom_range(1)));
  endfunction

  task automatic send_word(jpeg_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= w.data;
    first_byte <= w.first;
    last_byte  <= w.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_word(w.data, w.first, w.last)) walked_words++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_word(stream_q[i]);
    stream_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_word(8'hAA, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'h12, 1'b1, 1'b0);
    push_word(MARK_SOI, 1'b0, 1'b0);
    start_stream();
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(MARK_RST7, 1'b0, 1'b0);
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(MARK_SOS, 1'b0, 1'b0);
    push_word(8'h55, 1'b0, 1'b1);
    start_stream();
    push_word(8'h41, 1'b0, 1'b0);
    start_stream();
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(8'hE1, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'h01, 1'b0, 1'b0);
    start_stream();
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(MARK_EOI, 1'b0, 1'b1);
    send_stream();
    wait_drained();

    // A long payload, a truncated length of 0xFFFE and a zero length.
    start_stream();
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(8'hE2, 1'b0, 1'b0);
    push_word(8'h01, 1'b0, 1'b0);
    push_word(8'h23, 1'b0, 1'b0);
    repeat (16'h0123 - LEN_MIN) push_word(8'($urandom), 1'b0, 1'b0);
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(MARK_EOI, 1'b0, 1'b0);
    start_stream();
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(8'hE3, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'hFE, 1'b0, 1'b0);
    repeat (3) push_word(8'($urandom), 1'b0, 1'b0);
    push_word(8'($urandom), 1'b0, 1'b1);
    start_stream();
    push_word(BYTE_FILL, 1'b0, 1'b0);
    push_word(8'hE4, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    send_stream();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      goal = walked_words + PHASE_WORDS;
      while (walked_words < goal) begin
        gen_stream();
        send_stream();
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("jpeg_marker_segment_walker_test OK");
    end else begin
      $display("jpeg_marker_segment_walker_test NOT OK");
    end
    $finish;
  end

endmodule
